// ===== hdl/lens_distortion_pixel_map_defines.svh =====
// Assertion macros shared by the lens distortion checker.
`ifndef LENS_DISTORTION_PIXEL_MAP_DEFINES_SVH
`define LENS_DISTORTION_PIXEL_MAP_DEFINES_SVH

// Antecedent implies consequent a fixed number of cycles later.
`define LDPM_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LDPM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, checked during reset too.
`define LDPM_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ldpm_pkg.sv =====
// Shared constants, register indexes and saturation helpers of the lens distortion block.
package ldpm_pkg;

  localparam int DIV_STAGES = 32;
  localparam int LATENCY    = 48;

  localparam logic signed [63:0] Q_ONE64 = 64'sd268435456;
  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
  localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
  localparam logic signed [63:0] PIX_MAX64 = 64'sd8191;
  localparam logic signed [63:0] PIX_MIN64 = -64'sd8192;
  localparam logic signed [63:0] TRUNC_BIAS = 64'sd1099511627775;

  localparam logic signed [31:0] RADIAL_K3 = 32'sd0;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } cfg_reg_t;

  function automatic logic ovf_q(logic signed [63:0] v);
    return (v > Q_MAX64) || (v < Q_MIN64);
  endfunction

  function automatic logic signed [31:0] sat_q(logic signed [63:0] v);
    if (v > Q_MAX64) begin
      return Q_MAX;
    end else if (v < Q_MIN64) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hdl/lens_distortion_pixel_map.sv =====
// Top level: five-coefficient lens distortion of one pixel coordinate per cycle.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   pixel in | start, busy             | pixel_x, pixel_y
//   config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//   result   | done (one-cycle strobe) | mapped_x, mapped_y, clipped
//
// One pixel enters every cycle while busy is low; each pixel then passes through
// the normalization (an input stage, the 32-stage restoring divider and a result
// register) followed by 14 multiply, scale, saturate and output stages.
// busy is high only during reset; rst clears all valid bits and loads the lens registers with their defaults.
// Results are never held; the pipeline advances every cycle.
module lens_distortion_pixel_map import ldpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        pixel_x,
  input  logic [11:0]        pixel_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [13:0] mapped_x,
  output logic signed [13:0] mapped_y,
  output logic               clipped
);

  logic [23:0]        focal_x;
  logic [23:0]        focal_y;
  logic [23:0]        center_x;
  logic [23:0]        center_y;
  logic signed [31:0] radial_k1;
  logic signed [31:0] radial_k2;
  logic signed [31:0] tangential_p1;
  logic signed [31:0] tangential_p2;

  logic               norm_valid;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic               norm_sat;

  logic [13:1]        vld;
  logic [13:1]        sat;
  logic signed [31:0] xs [1:9];
  logic signed [31:0] ys [1:9];

  logic signed [63:0] p_xx, p_yy, p_xy;
  logic signed [31:0] xx, yy, xy, xx3, yy3, xy3, xy4;
  logic signed [31:0] r2, r2_4, r2_5, tx, ty, r4, r6;
  logic signed [63:0] p_r4, p_r6;
  logic signed [63:0] pt_a, pt_b, pt_c, pt_d;
  logic signed [63:0] pk1, pk1_6, pk1_7, pk1_8, pk2, pk2_7, pk2_8, pk3;
  logic signed [47:0] ta6, tb6, ta7, tb7, ta8, tb8, ta9, tb9, ta10, tb10;
  logic signed [31:0] f;
  logic signed [63:0] pxf, pyf;
  logic signed [31:0] ux, uy;
  logic signed [63:0] pmx, pmy, vx, vy;
  logic [14:0]        pix_x, pix_y;

  function automatic logic [14:0] to_pix(logic signed [63:0] v);
    logic signed [63:0] q;
    q = v[63] ? ((v + TRUNC_BIAS) >>> 40) : (v >>> 40);
    if (q > PIX_MAX64) begin
      return {1'b1, 14'sd8191};
    end else if (q < PIX_MIN64) begin
      return {1'b1, -14'sd8192};
    end
    return {1'b0, q[13:0]};
  endfunction

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign pix_x     = to_pix(vx);
  assign pix_y     = to_pix(vy);

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= 24'd2097152;
      focal_y       <= 24'd2097152;
      center_x      <= 24'd1310720;
      center_y      <= 24'd983040;
      radial_k1     <= '0;
      radial_k2     <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:  focal_x       <= cfg_data[23:0];
        REG_FOCAL_Y:  focal_y       <= cfg_data[23:0];
        REG_CENTER_X: center_x      <= cfg_data[23:0];
        REG_CENTER_Y: center_y      <= cfg_data[23:0];
        REG_K1:       radial_k1     <= cfg_data;
        REG_K2:       radial_k2     <= cfg_data;
        REG_P1:       tangential_p1 <= cfg_data;
        REG_P2:       tangential_p2 <= cfg_data;
        default:      ;
      endcase
    end
  end

  ldpm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .focal_x   (focal_x),
    .focal_y   (focal_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_valid (norm_valid),
    .norm_x    (norm_x),
    .norm_y    (norm_y),
    .norm_sat  (norm_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[12:1], norm_valid};
      done <= vld[13];
    end
  end

  always_ff @(posedge clk) begin
    xs[1] <= norm_x;
    ys[1] <= norm_y;
    for (int k = 1; k < 9; k++) begin
      xs[k+1] <= xs[k];
      ys[k+1] <= ys[k];
    end

    p_xx   <= norm_x * norm_x;
    p_yy   <= norm_y * norm_y;
    p_xy   <= norm_x * norm_y;
    sat[1] <= norm_sat;

    xx     <= sat_q(p_xx >>> 28);
    yy     <= sat_q(p_yy >>> 28);
    xy     <= sat_q(p_xy >>> 28);
    sat[2] <= sat[1] | ovf_q(p_xx >>> 28) | ovf_q(p_yy >>> 28) | ovf_q(p_xy >>> 28);

    r2     <= sat_q(64'(xx) + 64'(yy));
    xx3    <= xx;
    yy3    <= yy;
    xy3    <= xy;
    sat[3] <= sat[2] | ovf_q(64'(xx) + 64'(yy));

    tx     <= sat_q(64'(r2) + (64'(xx3) <<< 1));
    ty     <= sat_q(64'(r2) + (64'(yy3) <<< 1));
    p_r4   <= r2 * r2;
    r2_4   <= r2;
    xy4    <= xy3;
    sat[4] <= sat[3] | ovf_q(64'(r2) + (64'(xx3) <<< 1)) | ovf_q(64'(r2) + (64'(yy3) <<< 1));

    r4     <= sat_q(p_r4 >>> 28);
    pt_a   <= tangential_p1 * xy4;
    pt_b   <= tangential_p2 * tx;
    pt_c   <= tangential_p2 * xy4;
    pt_d   <= tangential_p1 * ty;
    pk1    <= radial_k1 * r2_4;
    r2_5   <= r2_4;
    sat[5] <= sat[4] | ovf_q(p_r4 >>> 28);

    p_r6   <= r4 * r2_5;
    pk2    <= radial_k2 * r4;
    pk1_6  <= pk1;
    ta6    <= 48'(((pt_a >>> 20) <<< 1) + (pt_b >>> 20));
    tb6    <= 48'(((pt_c >>> 20) <<< 1) + (pt_d >>> 20));
    sat[6] <= sat[5];

    r6     <= sat_q(p_r6 >>> 28);
    pk1_7  <= pk1_6;
    pk2_7  <= pk2;
    ta7    <= ta6;
    tb7    <= tb6;
    sat[7] <= sat[6] | ovf_q(p_r6 >>> 28);

    pk3    <= RADIAL_K3 * r6;
    pk1_8  <= pk1_7;
    pk2_8  <= pk2_7;
    ta8    <= ta7;
    tb8    <= tb7;
    sat[8] <= sat[7];

    f      <= sat_q(Q_ONE64 + (pk1_8 >>> 20) + (pk2_8 >>> 20) + (pk3 >>> 20));
    ta9    <= ta8;
    tb9    <= tb8;
    sat[9] <= sat[8] | ovf_q(Q_ONE64 + (pk1_8 >>> 20) + (pk2_8 >>> 20) + (pk3 >>> 20));

    pxf     <= xs[9] * f;
    pyf     <= ys[9] * f;
    ta10    <= ta9;
    tb10    <= tb9;
    sat[10] <= sat[9];

    ux      <= sat_q((pxf >>> 28) + 64'(ta10));
    uy      <= sat_q((pyf >>> 28) + 64'(tb10));
    sat[11] <= sat[10] | ovf_q((pxf >>> 28) + 64'(ta10)) | ovf_q((pyf >>> 28) + 64'(tb10));

    pmx     <= ux * $signed({1'b0, focal_x});
    pmy     <= uy * $signed({1'b0, focal_y});
    sat[12] <= sat[11];

    vx      <= pmx + $signed({12'b0, center_x, 28'b0});
    vy      <= pmy + $signed({12'b0, center_y, 28'b0});
    sat[13] <= sat[12];

    mapped_x <= pix_x[13:0];
    mapped_y <= pix_y[13:0];
    clipped  <= sat[13] | pix_x[14] | pix_y[14];
  end

endmodule

// ===== hdl/ldpm_norm.sv =====
// Pipelined normalization of both pixel coordinates by principal point and focal length.
module ldpm_norm import ldpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [11:0]        pixel_x,
  input  logic [11:0]        pixel_y,
  input  logic [23:0]        focal_x,
  input  logic [23:0]        focal_y,
  input  logic [23:0]        center_x,
  input  logic [23:0]        center_y,
  output logic               out_valid,
  output logic signed [31:0] norm_x,
  output logic signed [31:0] norm_y,
  output logic               norm_sat
);

  typedef struct packed {
    logic [24:0] rem;
    logic [31:0] quo;
    logic [3:0]  low;
    logic        neg;
    logic        big;
  } div_lane_t;

  logic [DIV_STAGES:0] valid;
  div_lane_t           lane_x [0:DIV_STAGES];
  div_lane_t           lane_y [0:DIV_STAGES];
  logic [23:0]         div_x;
  logic [23:0]         div_y;
  logic [32:0]         res_x;
  logic [32:0]         res_y;

  function automatic div_lane_t lane_init(logic [11:0] pix, logic [23:0] center,
                                          logic [23:0] div);
    logic signed [24:0] diff;
    logic [24:0]        mag;
    div_lane_t          l;
    diff  = $signed({1'b0, pix, 12'b0}) - $signed({1'b0, center});
    mag   = diff[24] ? $unsigned(-diff) : $unsigned(diff);
    l.rem = {4'b0, mag[24:4]};
    l.quo = '0;
    l.low = mag[3:0];
    l.neg = diff[24];
    l.big = {3'b0, mag} >= {div, 4'b0};
    return l;
  endfunction

  function automatic div_lane_t lane_step(div_lane_t l, logic [23:0] div);
    logic [24:0] trial;
    div_lane_t   n;
    n     = l;
    trial = {l.rem[23:0], l.low[3]};
    if (trial >= {1'b0, div}) begin
      n.rem = trial - {1'b0, div};
      n.quo = {l.quo[30:0], 1'b1};
    end else begin
      n.rem = trial;
      n.quo = {l.quo[30:0], 1'b0};
    end
    n.low = {l.low[2:0], 1'b0};
    return n;
  endfunction

  function automatic logic [32:0] lane_result(div_lane_t l);
    if (l.big) begin
      return {1'b1, l.neg ? Q_MIN : Q_MAX};
    end else if (!l.neg) begin
      if (l.quo[31]) begin
        return {1'b1, Q_MAX};
      end
      return {1'b0, l.quo};
    end else if (l.quo > 32'h80000000) begin
      return {1'b1, Q_MIN};
    end
    return {1'b0, 32'(-l.quo)};
  endfunction

  assign div_x = (focal_x == '0) ? 24'd1 : focal_x;
  assign div_y = (focal_y == '0) ? 24'd1 : focal_y;
  assign res_x = lane_result(lane_x[DIV_STAGES]);
  assign res_y = lane_result(lane_y[DIV_STAGES]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      valid     <= {valid[DIV_STAGES-1:0], in_valid};
      out_valid <= valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    lane_x[0] <= lane_init(pixel_x, center_x, div_x);
    lane_y[0] <= lane_init(pixel_y, center_y, div_y);
    for (int k = 0; k < DIV_STAGES; k++) begin
      lane_x[k+1] <= lane_step(lane_x[k], div_x);
      lane_y[k+1] <= lane_step(lane_y[k], div_y);
    end
    norm_x   <= res_x[31:0];
    norm_y   <= res_y[31:0];
    norm_sat <= res_x[32] | res_y[32];
  end

endmodule

// ===== hdl/ldpm_checker.sv =====
// Port-level checker of the lens distortion block and its bind.
`include "lens_distortion_pixel_map_defines.svh"

module ldpm_checker import ldpm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `LDPM_ASSERT_DELAY(a_latency, clk, rst, start && !busy, LATENCY, done, "result missing")
  `LDPM_ASSERT_IMP(a_no_extra, clk, rst, done, $past(start && !busy, LATENCY), "unexpected result")
  `LDPM_ASSERT_NEXT(a_reset_flush, clk, rst, !done, "result after reset")

endmodule

bind lens_distortion_pixel_map ldpm_checker u_ldpm_checker (.*);

// ===== tb/lens_distortion_pixel_map_tb.sv =====
// Testbench for the lens distortion pixel map: queued stimulus, in-order result check.
module lens_distortion_pixel_map_tb;
  import ldpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
  } pixel_t;

  typedef struct packed {
    logic signed [13:0] mx;
    logic signed [13:0] my;
    logic               clip;
  } mapped_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [13:0] mapped_x;
  logic signed [13:0] mapped_y;
  logic clipped;

  lens_distortion_pixel_map i_dut (
    .clk, .rst, .start, .busy, .pixel_x, .pixel_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .mapped_x, .mapped_y, .clipped
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the lens registers
  longint lens_fx, lens_fy, lens_cx, lens_cy, lens_k1, lens_k2, lens_p1, lens_p2;

  pixel_t  pixel_queue[$];
  mapped_t mapped_expected[$];
  int  idle_burst = 0;
  bit  idle_enable = 1'b1;
  int  mismatch_count = 0;
  int  result_count = 0;
  int  clip_count = 0;
  longint cycle_count = 0;
  logic accepted = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_q28(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint clamp_pixel(longint v, ref bit sat);
    if (v > 8191) begin
      sat = 1'b1;
      return 8191;
    end
    if (v < -8192) begin
      sat = 1'b1;
      return -8192;
    end
    return v;
  endfunction

  function automatic longint norm_coord(longint pix, longint ctr, longint foc, ref bit sat);
    longint diff;
    longint div;
    diff = (pix <<< 12) - ctr;
    div = (foc == 0) ? 1 : foc;
    return sat_q28((diff * 64'sd268435456) / div, sat);
  endfunction

  function automatic longint back_map(longint u, longint foc, longint ctr, ref bit sat);
    longint v;
    v = u * foc + ctr * 64'sd268435456;
    return clamp_pixel(v / 64'sd1099511627776, sat);
  endfunction

  function automatic mapped_t distort_pixel(pixel_t p);
    bit sat;
    longint k3, x, y, xx, yy, xy, r2, r4, r6, f, tx, ty, ux, uy;
    mapped_t m;
    sat = 1'b0;
    k3 = longint'(RADIAL_K3);
    x  = norm_coord(longint'(p.px), lens_cx, lens_fx, sat);
    y  = norm_coord(longint'(p.py), lens_cy, lens_fy, sat);
    xx = sat_q28(floor_shr(x * x, 28), sat);
    yy = sat_q28(floor_shr(y * y, 28), sat);
    xy = sat_q28(floor_shr(x * y, 28), sat);
    r2 = sat_q28(xx + yy, sat);
    r4 = sat_q28(floor_shr(r2 * r2, 28), sat);
    r6 = sat_q28(floor_shr(r4 * r2, 28), sat);
    f  = sat_q28(64'sd268435456 + floor_shr(lens_k1 * r2, 20) + floor_shr(lens_k2 * r4, 20)
                 + floor_shr(k3 * r6, 20), sat);
    tx = sat_q28(r2 + 2 * xx, sat);
    ty = sat_q28(r2 + 2 * yy, sat);
    ux = sat_q28(floor_shr(x * f, 28) + 2 * floor_shr(lens_p1 * xy, 20)
                 + floor_shr(lens_p2 * tx, 20), sat);
    uy = sat_q28(floor_shr(y * f, 28) + 2 * floor_shr(lens_p2 * xy, 20)
                 + floor_shr(lens_p1 * ty, 20), sat);
    m.mx = 14'(back_map(ux, lens_fx, lens_cx, sat));
    m.my = 14'(back_map(uy, lens_fy, lens_cy, sat));
    m.clip = sat;
    return m;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (idle_burst > 0) begin
        idle_burst <= idle_burst - 1;
        start <= 1'b0;
      end else if (pixel_queue.size() > 0 && (!start || accepted)) begin
        if (idle_enable && $urandom_range(0, 15) == 0) begin
          idle_burst <= $urandom_range(0, 10);
          start <= 1'b0;
        end else begin
          pixel_x <= pixel_queue[0].px;
          pixel_y <= pixel_queue[0].py;
          mapped_expected.insert(mapped_expected.size(),
                                 distort_pixel(pixel_queue.pop_front()));
          start <= 1'b1;
        end
      end else if (pixel_queue.size() == 0 && (!start || accepted)) begin
        start <= 1'b0;
      end
    end
  end

  // accept flag, sampled at the rising edge
  always @(posedge clk) begin
    accepted <= start && !busy;
  end

  // monitor
  always @(posedge clk) begin
    mapped_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      result_count <= result_count + 1;
      if (clipped) begin
        clip_count <= clip_count + 1;
      end
      if (mapped_expected.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("unexpected result x=%0d y=%0d clip=%0b", mapped_x, mapped_y, clipped);
        end
      end else begin
        want = mapped_expected.pop_front();
        if (want.mx !== mapped_x || want.my !== mapped_y || want.clip !== clipped) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("mismatch: expected x=%0d y=%0d clip=%0b, got x=%0d y=%0d clip=%0b",
                     want.mx, want.my, want.clip, mapped_x, mapped_y, clipped);
          end
        end
      end
    end
  end

  task automatic write_lens_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOCAL_X:  lens_fx = longint'(val[23:0]);
      REG_FOCAL_Y:  lens_fy = longint'(val[23:0]);
      REG_CENTER_X: lens_cx = longint'(val[23:0]);
      REG_CENTER_Y: lens_cy = longint'(val[23:0]);
      REG_K1:       lens_k1 = longint'(signed'(val));
      REG_K2:       lens_k2 = longint'(signed'(val));
      REG_P1:       lens_p1 = longint'(signed'(val));
      REG_P2:       lens_p2 = longint'(signed'(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pixel_queue.size() > 0 || start || mapped_expected.size() > 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic queue_pixel(logic [11:0] x, logic [11:0] y);
    pixel_t p;
    p.px = x;
    p.py = y;
    pixel_queue.insert(pixel_queue.size(), p);
  endtask

  task automatic queue_random(int n, bit small_view);
    repeat (n) begin
      if (small_view) begin
        queue_pixel(12'($urandom_range(0, 1279)), 12'($urandom_range(0, 959)));
      end else begin
        queue_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  task automatic random_lens(int mode);
    write_lens_reg(REG_FOCAL_X, 32'($urandom_range(4096, 16777215)));
    write_lens_reg(REG_FOCAL_Y, (mode == 0) ? 32'($urandom_range(0, 16777215))
                                            : 32'($urandom_range(409600, 8388608)));
    write_lens_reg(REG_CENTER_X, 32'($urandom_range(0, 16777215)));
    write_lens_reg(REG_CENTER_Y, 32'($urandom));
    if (mode == 0) begin
      write_lens_reg(REG_K1, $urandom);
      write_lens_reg(REG_K2, $urandom);
      write_lens_reg(REG_P1, $urandom);
      write_lens_reg(REG_P2, $urandom);
    end else begin
      write_lens_reg(REG_K1, 32'(int'($urandom_range(0, 2097152)) - 1048576));
      write_lens_reg(REG_K2, 32'(int'($urandom_range(0, 1048576)) - 524288));
      write_lens_reg(REG_P1, 32'(int'($urandom_range(0, 65536)) - 32768));
      write_lens_reg(REG_P2, 32'(int'($urandom_range(0, 65536)) - 32768));
    end
  endtask

  initial begin
    lens_fx = 2097152;
    lens_fy = 2097152;
    lens_cx = 1310720;
    lens_cy = 983040;
    lens_k1 = 0;
    lens_k2 = 0;
    lens_p1 = 0;
    lens_p2 = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset lens: corners and center
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd320, 12'd240);
    queue_pixel(12'd4095, 12'd0);
    queue_pixel(12'd0, 12'd4095);
    queue_pixel(12'hAAA, 12'h555);
    drain_pipeline();

    // extreme coefficients and zero focal length
    write_lens_reg(REG_FOCAL_X, 32'd0);
    write_lens_reg(REG_FOCAL_Y, 32'h00FFFFFF);
    write_lens_reg(REG_CENTER_X, 32'h00FFFFFF);
    write_lens_reg(REG_CENTER_Y, 32'd0);
    write_lens_reg(REG_K1, 32'h7FFFFFFF);
    write_lens_reg(REG_K2, 32'h80000000);
    write_lens_reg(REG_P1, 32'h80000000);
    write_lens_reg(REG_P2, 32'h7FFFFFFF);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd4095, 12'd0);
    queue_pixel(12'd1, 12'd2048);
    drain_pipeline();

    // mild barrel lens, mostly in range
    write_lens_reg(REG_FOCAL_X, 32'd2097152);
    write_lens_reg(REG_FOCAL_Y, 32'd2097152);
    write_lens_reg(REG_CENTER_X, 32'd1310720);
    write_lens_reg(REG_CENTER_Y, 32'd983040);
    write_lens_reg(REG_K1, -32'sd200000);
    write_lens_reg(REG_K2, 32'sd50000);
    write_lens_reg(REG_P1, 32'sd1000);
    write_lens_reg(REG_P2, -32'sd1000);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd639, 12'd479);
    queue_pixel(12'd320, 12'd240);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd100, 12'd400);
    drain_pipeline();

    for (int phase = 0; phase < 8; phase++) begin
      random_lens((phase % 3 == 0) ? 0 : 1);
      queue_random(205, phase % 2 == 1);
      drain_pipeline();
      if (phase == 3) begin
        // hold off until everything has returned
        queue_random(40, 1'b1);
        drain_pipeline();
      end
    end

    idle_enable = 1'b0;
    queue_random(200, 1'b1);
    drain_pipeline();

    $display("Covered %0d results (%0d saturated) over several lens settings,",
             result_count, clip_count);
    $display("including zero focal length and extreme coefficients.");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("timeout");
      $display("TEST FAILED");
      $finish;
    end
  end
endmodule
